// ===== hw/rtl/lnf_pkg.sv =====
// lnf_pkg: shared constants, command and status types of the layer norm core
`default_nettype none
package lnf_pkg;

  localparam int MAX_ELEMS  = 64;
  localparam int DATA_WIDTH = 16;
  localparam int CNT_W      = $clog2(MAX_ELEMS + 1);
  localparam int ADDR_W     = $clog2(MAX_ELEMS);
  localparam int SUM_W      = 22;
  localparam int SQ_W       = 38;
  localparam int EPS_W      = 16;
  localparam int OUT_W      = 16;
  localparam int NQ_W       = 45;
  localparam int NN_W       = 2 * CNT_W;
  localparam int EN_W       = EPS_W + NN_W;
  localparam int DV_W       = NQ_W + 1;
  localparam int B_W        = DV_W + CNT_W;
  localparam int D_W        = 24;
  localparam int AD_W       = 23;
  localparam int SQ2_W      = 2 * AD_W;
  localparam int A_W        = 52;
  localparam int SAT_SHIFT  = 6;
  localparam int CMP_W      = B_W + SAT_SHIFT;
  localparam int R_W        = B_W + 1;
  localparam int QUO_W      = 30;
  localparam int FRAC_BITS  = 24;
  localparam int ROOT_W     = QUO_W / 2;
  localparam int RM_W       = ROOT_W + 3;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int ITER_W     = $clog2(DIV_STEPS);
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
  localparam logic [OUT_W-1:0] SAT_POS   = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG   = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_NONE, OP_ACC, OP_ST1, OP_ST2, OP_ST3, OP_ST4, OP_RD, OP_LD_D,
    OP_LD_SQ, OP_LD_A, OP_DIV_INIT, OP_DIV_STEP, OP_SQ_INIT, OP_SQ_STEP, OP_EMIT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             skip;
    logic             out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lnf_ram.sv =====
// lnf_ram: generic single write, single read RAM with registered read
`default_nettype none
module lnf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lnf_ctrl.sv =====
// lnf_ctrl: sequencing state machine of the layer norm core
`default_nettype none
module lnf_ctrl import lnf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic is_last_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  typedef enum logic [14:0] {
    S_COLLECT = 15'b000000000000001,
    S_ST1     = 15'b000000000000010,
    S_ST2     = 15'b000000000000100,
    S_ST3     = 15'b000000000001000,
    S_ST4     = 15'b000000000010000,
    S_RD      = 15'b000000000100000,
    S_LDD     = 15'b000000001000000,
    S_LDSQ    = 15'b000000010000000,
    S_LDA     = 15'b000000100000000,
    S_CHK     = 15'b000001000000000,
    S_DIV     = 15'b000010000000000,
    S_SQI     = 15'b000100000000000,
    S_SQ      = 15'b001000000000000,
    S_EMIT    = 15'b010000000000000,
    S_SPARE   = 15'b100000000000000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [ITER_W-1:0]  it_q, it_d;
  logic               last_elem;

  assign in_ready_o = (state_q == S_COLLECT);
  assign last_elem  = ((k_q + CNT_W'(1)) == sts_i.count);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    it_d    = it_q;
    cmd_o   = '{op: OP_NONE, addr: k_q[ADDR_W-1:0], last: 1'b0};
    unique case (state_q)
      S_COLLECT: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACC;
          if (is_last_i) begin
            state_d = S_ST1;
          end
        end
      end
      S_ST1: begin
        cmd_o.op = OP_ST1;
        state_d  = S_ST2;
      end
      S_ST2: begin
        cmd_o.op = OP_ST2;
        state_d  = S_ST3;
      end
      S_ST3: begin
        cmd_o.op = OP_ST3;
        state_d  = S_ST4;
      end
      S_ST4: begin
        cmd_o.op = OP_ST4;
        k_d      = '0;
        state_d  = S_RD;
      end
      S_RD: begin
        cmd_o.op = OP_RD;
        state_d  = S_LDD;
      end
      S_LDD: begin
        cmd_o.op = OP_LD_D;
        state_d  = S_LDSQ;
      end
      S_LDSQ: begin
        cmd_o.op = OP_LD_SQ;
        state_d  = S_LDA;
      end
      S_LDA: begin
        cmd_o.op = OP_LD_A;
        state_d  = S_CHK;
      end
      S_CHK: begin
        cmd_o.op = OP_DIV_INIT;
        it_d     = ITER_W'(DIV_STEPS - 1);
        state_d  = sts_i.skip ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (it_q == '0) begin
          state_d = S_SQI;
        end else begin
          it_d = it_q - ITER_W'(1);
        end
      end
      S_SQI: begin
        cmd_o.op = OP_SQ_INIT;
        it_d     = ITER_W'(SQRT_STEPS - 1);
        state_d  = S_SQ;
      end
      S_SQ: begin
        cmd_o.op = OP_SQ_STEP;
        if (it_q == '0) begin
          state_d = S_EMIT;
        end else begin
          it_d = it_q - ITER_W'(1);
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op   = OP_EMIT;
          cmd_o.last = last_elem;
          if (last_elem) begin
            state_d = S_COLLECT;
          end else begin
            k_d     = k_q + CNT_W'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
      k_q     <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      it_q    <= it_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/lnf_datapath.sv =====
// lnf_datapath: element buffer, statistics, divider, square root and output register
`default_nettype none
module lnf_datapath import lnf_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cmd_t                         cmd_i,
  input  wire logic signed [DATA_WIDTH-1:0] sample_value_i,
  input  wire logic                         cfg_we_i,
  input  wire logic        [EPS_W-1:0]      cfg_wdata_i,
  input  wire logic                         out_ready_i,
  output sts_t                              sts_o,
  output logic                              out_valid_o,
  output logic signed      [OUT_W-1:0]      normalized_value_o,
  output logic                              out_last_o
);

  logic [EPS_W-1:0]         eps_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SQ_W-1:0]          sqs_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     out_valid_q;
  logic [OUT_W-1:0]         out_val_q;
  logic                     out_last_q;

  logic [NQ_W-1:0]          nq_q, ss_q, num_q;
  logic [NN_W-1:0]          nn1_q;
  logic [EN_W-1:0]          en_q;
  logic [DV_W-1:0]          dv_q;
  logic [B_W-1:0]           b_q;
  logic signed [D_W-1:0]    d_q;
  logic                     neg_q, zero_q, sat_q;
  logic [SQ2_W-1:0]         sq_q;
  logic [A_W-1:0]           a_q;
  logic [R_W-1:0]           r_q;
  logic [QUO_W-1:0]         sh_q, quo_q, src_q;
  logic [RM_W-1:0]          rem_q;
  logic [ROOT_W-1:0]        root_q;

  logic                     full;
  logic signed [2*DATA_WIDTH-1:0] x_sq;
  logic signed [2*SUM_W-1:0] s_sq;
  logic [DATA_WIDTH-1:0]    rdata;
  logic signed [D_W-1:0]    nx;
  logic [AD_W-1:0]          ad;
  logic                     sat_cmp;
  logic [R_W-1:0]           div_t;
  logic [RM_W-1:0]          sq_t, trial;
  logic [OUT_W-1:0]         root_ext, res;

  assign full  = (cnt_q == CNT_W'(MAX_ELEMS));
  assign x_sq  = sample_value_i * sample_value_i;
  assign s_sq  = (2*SUM_W)'(sum_q) * (2*SUM_W)'(sum_q);

  lnf_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMS)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_ACC && !full),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (sample_value_i),
    .re_i    (cmd_i.op == OP_RD),
    .raddr_i (cmd_i.addr),
    .rdata_o (rdata)
  );

  assign nx      = D_W'($signed({1'b0, cnt_q})) * D_W'($signed(rdata));
  assign ad      = AD_W'(d_q[D_W-1] ? -d_q : d_q);
  assign sat_cmp = (CMP_W'(a_q) >= {b_q, {SAT_SHIFT{1'b0}}});
  assign div_t   = {r_q[R_W-2:0], sh_q[QUO_W-1]};
  assign sq_t    = {rem_q[RM_W-3:0], src_q[QUO_W-1 -: 2]};
  assign trial   = RM_W'({root_q, 2'b01});
  assign root_ext = OUT_W'(root_q);

  always_comb begin
    priority if (zero_q) begin
      res = '0;
    end else if (sat_q) begin
      res = neg_q ? SAT_NEG : SAT_POS;
    end else begin
      res = neg_q ? -root_ext : root_ext;
    end
  end

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q       <= EPS_RESET;
      sum_q       <= '0;
      sqs_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        eps_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_ACC && !full) begin
        sum_q <= sum_q + SUM_W'(sample_value_i);
        sqs_q <= sqs_q + SQ_W'($unsigned(x_sq));
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (cmd_i.op == OP_EMIT && cmd_i.last) begin
        sum_q <= '0;
        sqs_q <= '0;
        cnt_q <= '0;
      end
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // arithmetic pipeline registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_ST1: begin
        nq_q  <= NQ_W'(cnt_q) * NQ_W'(sqs_q);
        ss_q  <= NQ_W'($unsigned(s_sq));
        nn1_q <= NN_W'(cnt_q) * NN_W'(cnt_q - CNT_W'(1));
      end
      OP_ST2: begin
        num_q <= (nq_q >= ss_q) ? nq_q - ss_q : '0;
        en_q  <= EN_W'(eps_q) * EN_W'(nn1_q);
      end
      OP_ST3: dv_q <= DV_W'(num_q) + DV_W'(en_q);
      OP_ST4: b_q  <= B_W'(cnt_q) * B_W'(dv_q);
      OP_LD_D: d_q <= nx - D_W'(sum_q);
      OP_LD_SQ: begin
        neg_q  <= d_q[D_W-1];
        zero_q <= (d_q == '0) || (cnt_q <= CNT_W'(1));
        sq_q   <= SQ2_W'(ad) * SQ2_W'(ad);
      end
      OP_LD_A: a_q <= A_W'(sq_q) * A_W'(cnt_q - CNT_W'(1));
      OP_DIV_INIT: begin
        sat_q <= sat_cmp;
        r_q   <= R_W'(a_q >> SAT_SHIFT);
        sh_q  <= {a_q[SAT_SHIFT-1:0], {FRAC_BITS{1'b0}}};
        quo_q <= '0;
      end
      OP_DIV_STEP: begin
        sh_q <= {sh_q[QUO_W-2:0], 1'b0};
        if (div_t >= R_W'(b_q)) begin
          r_q   <= div_t - R_W'(b_q);
          quo_q <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          r_q   <= div_t;
          quo_q <= {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      OP_SQ_INIT: begin
        src_q  <= quo_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_SQ_STEP: begin
        src_q <= {src_q[QUO_W-3:0], 2'b00};
        if (sq_t >= trial) begin
          rem_q  <= sq_t - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= sq_t;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
      end
      OP_EMIT: begin
        out_val_q  <= res;
        out_last_q <= cmd_i.last;
      end
      default: begin
      end
    endcase
  end

  assign sts_o.count    = cnt_q;
  assign sts_o.skip     = zero_q | sat_cmp;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign normalized_value_o = $signed(out_val_q);
  assign out_last_o         = out_last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/layer_norm_forward_core.sv =====
// layer_norm_forward_core: top level of the layer normalisation forward core
//
// usage
//   input channel (in_valid_i / in_ready_o) carries one Q8.8 element per request,
//   is_last_i closing the sample; elements are taken one per cycle while collecting
//   up to 64 elements are buffered; further ones are dropped but is_last still closes
//   after the closing request: statistics (mean, unbiased variance) are formed,
//   then each element is normalised in turn and sent on the output channel
//   (out_valid_o / out_ready_i) as Q4.12, saturated, out_last_o on the final one
//   per element: the divider (one quotient bit per cycle) and the square root
//   (one root bit per cycle) run, and both are skipped when the result is zero
//   or saturated; the two iterative units set the rate
//   no new input request is taken until the last result of a sample is loaded
//   into the output register; a stalled receiver holds that register and the
//   sequencer waits before the next element; epsilon (cfg_we_i / cfg_wdata_i, Q0.16)
//   resets to 1 LSB and must be written while idle, which the block does not enforce;
//   reset clears the sums, the count and the output valid; the buffer needs no clear
`default_nettype none
module layer_norm_forward_core import lnf_pkg::*; (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [DATA_WIDTH-1:0] sample_value_i,
  input  wire logic                         is_last_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed      [OUT_W-1:0]      normalized_value_o,
  output logic                              out_last_o,
  input  wire logic                         cfg_we_i,
  input  wire logic        [EPS_W-1:0]      cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: collection, statistics, per element iteration
  lnf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .is_last_i  (is_last_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic, element buffer and output register
  lnf_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sample_value_i     (sample_value_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .out_ready_i        (out_ready_i),
    .sts_o              (sts),
    .out_valid_o        (out_valid_o),
    .normalized_value_o (normalized_value_o),
    .out_last_o         (out_last_o)
  );

  // a result is never loaded over one still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_EMIT |-> sts.out_free)
    else $error("result loaded over pending output");

  // the element count never exceeds the buffer depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= CNT_W'(MAX_ELEMS))
    else $error("element count beyond buffer depth");

  // accumulation only on an accepted input request
  a_acc_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_ACC |-> in_valid_i && in_ready_o)
    else $error("accumulate without input request");

  // the final result of a sample clears the count
  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_EMIT && cmd.last |=> sts.count == '0)
    else $error("count not cleared after sample");

endmodule
`default_nettype wire
